// ===== hdl/windowed_burst_detector_assert.svh =====
// ----------------------------------------------------------------------------
// Windowed burst detector assertion macros
// Short forms for the clocked, reset-qualified properties used by the checker.
// ----------------------------------------------------------------------------
`ifndef WINDOWED_BURST_DETECTOR_ASSERT_SVH
`define WINDOWED_BURST_DETECTOR_ASSERT_SVH

// same-cycle implication
`define WBD_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("windowed_burst_detector: assertion failed");

// next-cycle implication
`define WBD_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("windowed_burst_detector: assertion failed");

`endif

// ===== hdl/wbd_pkg.sv =====
// ----------------------------------------------------------------------------
// Windowed burst detector package
// Widths, reset values, register indexes and controller/datapath interface types.
// ----------------------------------------------------------------------------
`default_nettype none

package wbd_pkg;

	localparam int SAMPLE_BITS   = 16;
	localparam int COUNT_BITS    = 24;
	localparam int FRAC_BITS     = 8;
	localparam int INDEX_BITS    = COUNT_BITS + 1;
	localparam int THRESH_BITS   = SAMPLE_BITS + 1;
	localparam int PROD_BITS     = SAMPLE_BITS + FRAC_BITS;
	localparam int CFG_DATA_BITS = COUNT_BITS;
	localparam int CFG_IDX_BITS  = 2;
	localparam int DIV_CNT_BITS  = $clog2(COUNT_BITS + 1);

	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
	localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [INDEX_BITS-1:0] INDEX_MAX = {INDEX_BITS{1'b1}};

	localparam logic [COUNT_BITS-1:0] WINDOW_RESET = COUNT_BITS'(50000);
	localparam logic [FRAC_BITS-1:0]  LOW_RESET    = FRAC_BITS'(26);
	localparam logic [FRAC_BITS-1:0]  HIGH_RESET   = FRAC_BITS'(230);

	typedef enum logic [CFG_IDX_BITS-1:0] {
		CFG_WINDOW_SAMPLES = 2'd0,
		CFG_LOW_FRACTION   = 2'd1,
		CFG_HIGH_FRACTION  = 2'd2
	} cfg_index_t;

	// commands from controller to datapath
	typedef struct packed {
		logic upd;       // plain sample update at accept
		logic cap;       // capture window-closing sample
		logic mul;       // register range * fraction products
		logic thr;       // latch new thresholds
		logic div_start; // start mean interval division
		logic fin;       // emit result, restart window, apply captured sample
	} dp_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic close_due;
		logic div_busy;
		logic out_free;
	} dp_status_t;

endpackage

`default_nettype wire

// ===== hdl/windowed_burst_detector.sv =====
// ----------------------------------------------------------------------------
// Windowed burst detector
// Running window min/max, hysteresis burst detection and per-window statistics.
// ----------------------------------------------------------------------------
// Takes one signed sample per item and keeps the min and max of a window of
// window_samples+1 samples. The min and range of the last closed window set
// the low and high thresholds (fractions of range in 1/256 steps) that drive
// a hysteresis burst detector; detection is off until the first window has
// closed. The first sample past the window closes it and yields one result:
// min, max, onset count, truncated mean onset interval (zero and mean_valid
// low when there were no onsets) and the burst state after that sample.
// Ordinary samples are taken back to back. Once the sample that closes a
// window is taken, sample_stall stays high while the controller steps
// through MUL (the two threshold products), THR (latch thresholds and
// start the one-bit-per-cycle mean interval divider), DIV (wait for the
// divider) and FIN (emit the result); FIN also holds while a previous
// result still waits on result_stall.
// Configuration is taken on any cycle with cfg_we high; write it only while
// the block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_burst_detector
	import wbd_pkg::*;
(
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// configuration write port
	input  wire logic                          cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]      cfg_data,
	// sample channel
	input  wire logic                          sample_valid,
	output logic                               sample_stall,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	// result channel
	output logic                               result_valid,
	input  wire logic                          result_stall,
	output logic signed [SAMPLE_BITS-1:0]      window_min,
	output logic signed [SAMPLE_BITS-1:0]      window_max,
	output logic [COUNT_BITS-1:0]              onset_count,
	output logic [COUNT_BITS-1:0]              mean_interval,
	output logic                               mean_valid,
	output logic                               in_burst
);

	dp_cmd_t    cmd;
	dp_status_t status;

	// controller: accepts items, runs the close sequence
	wbd_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample_valid),
		.sample_stall (sample_stall),
		.status       (status),
		.cmd          (cmd)
	);

	// datapath: window state, thresholds, divider, result register
	wbd_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.sample        (sample),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.result_stall  (result_stall),
		.result_valid  (result_valid),
		.window_min    (window_min),
		.window_max    (window_max),
		.onset_count   (onset_count),
		.mean_interval (mean_interval),
		.mean_valid    (mean_valid),
		.in_burst      (in_burst)
	);

endmodule

`default_nettype wire

// ===== hdl/wbd_ctrl.sv =====
// ----------------------------------------------------------------------------
// Windowed burst detector controller
// Sequences ordinary samples and the multi-cycle window close.
// ----------------------------------------------------------------------------
`default_nettype none

module wbd_ctrl
	import wbd_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       sample_valid,
	output logic            sample_stall,
	input  wire dp_status_t status,
	output dp_cmd_t         cmd
);

	typedef enum logic [4:0] {
		ST_IDLE = 5'b00001,
		ST_MUL  = 5'b00010,
		ST_THR  = 5'b00100,
		ST_DIV  = 5'b01000,
		ST_FIN  = 5'b10000
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		sample_stall = (state_q != ST_IDLE);
		case (state_q)
			ST_IDLE: begin
				if (sample_valid) begin
					if (status.close_due) begin
						cmd.cap = 1'b1;
						state_d = ST_MUL;
					end else begin
						cmd.upd = 1'b1;
					end
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_THR;
			end
			ST_THR: begin
				cmd.thr       = 1'b1;
				cmd.div_start = 1'b1;
				state_d       = ST_DIV;
			end
			ST_DIV: begin
				if (!status.div_busy) begin
					state_d = ST_FIN;
				end
			end
			ST_FIN: begin
				// hold until the output register can take the result
				if (status.out_free) begin
					cmd.fin = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/wbd_div.sv =====
// ----------------------------------------------------------------------------
// Windowed burst detector divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wbd_div
	import wbd_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [COUNT_BITS-1:0] dividend,
	input  wire logic [COUNT_BITS-1:0] divisor,
	output logic                       busy,
	output logic [COUNT_BITS-1:0]      quotient
);

	logic                    busy_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0]   rem_q;
	logic [COUNT_BITS-1:0]   quo_q;
	logic [COUNT_BITS-1:0]   dvs_q;
	logic [COUNT_BITS:0]     trial;
	logic                    fits;

	assign trial = {rem_q, quo_q[COUNT_BITS-1]};
	assign fits  = (trial >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_BITS'(COUNT_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == DIV_CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= COUNT_BITS'(trial - {1'b0, dvs_q});
			end else begin
				rem_q <= trial[COUNT_BITS-1:0];
			end
			quo_q <= {quo_q[COUNT_BITS-2:0], fits};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ===== hdl/wbd_dp.sv =====
// ----------------------------------------------------------------------------
// Windowed burst detector datapath
// Window statistics, thresholds, hysteresis, divider and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module wbd_dp
	import wbd_pkg::*;
(
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire dp_cmd_t                      cmd,
	output dp_status_t                        status,
	input  wire logic signed [SAMPLE_BITS-1:0] sample,
	input  wire logic                         cfg_we,
	input  wire logic [CFG_IDX_BITS-1:0]      cfg_index,
	input  wire logic [CFG_DATA_BITS-1:0]     cfg_data,
	input  wire logic                         result_stall,
	output logic                              result_valid,
	output logic signed [SAMPLE_BITS-1:0]     window_min,
	output logic signed [SAMPLE_BITS-1:0]     window_max,
	output logic [COUNT_BITS-1:0]             onset_count,
	output logic [COUNT_BITS-1:0]             mean_interval,
	output logic                              mean_valid,
	output logic                              in_burst
);

	// configuration
	logic [COUNT_BITS-1:0] window_samples_q;
	logic [FRAC_BITS-1:0]  low_frac_q;
	logic [FRAC_BITS-1:0]  high_frac_q;

	// window state
	logic signed [SAMPLE_BITS-1:0] run_min_q, run_max_q;
	logic signed [THRESH_BITS-1:0] thresh_low_q, thresh_high_q;
	logic [INDEX_BITS-1:0]         sample_index_q;
	logic [COUNT_BITS-1:0]         onsets_q, interval_sum_q, last_onset_q;
	logic                          burst_q, primed_q;

	// close sequence
	logic signed [SAMPLE_BITS-1:0] samp_q;
	logic [PROD_BITS-1:0]          prod_lo_q, prod_hi_q;
	logic [THRESH_BITS-1:0]        diff;
	logic [SAMPLE_BITS-1:0]        range;
	logic                          div_busy;
	logic [COUNT_BITS-1:0]         quotient;

	// result register
	logic                          result_valid_q;
	logic signed [SAMPLE_BITS-1:0] window_min_q, window_max_q;
	logic [COUNT_BITS-1:0]         onset_count_q, mean_interval_q;
	logic                          mean_valid_q, in_burst_q;

	// sample update
	logic signed [SAMPLE_BITS-1:0] s_sel, b_min, b_max, n_min, n_max;
	logic signed [THRESH_BITS-1:0] s_ext;
	logic [INDEX_BITS-1:0]         b_idx, n_idx, gap;
	logic [COUNT_BITS-1:0]         b_ons, b_sum, b_last, n_ons, n_sum, n_last;
	logic [COUNT_BITS+1:0]         sum_w;
	logic                          b_primed, onset, leave, n_burst;

	always_comb begin
		// a window close restarts the window before the sample is applied
		s_sel    = cmd.fin ? samp_q : sample;
		b_min    = cmd.fin ? SAMPLE_MAX : run_min_q;
		b_max    = cmd.fin ? SAMPLE_MIN : run_max_q;
		b_idx    = cmd.fin ? '0 : sample_index_q;
		b_ons    = cmd.fin ? '0 : onsets_q;
		b_sum    = cmd.fin ? '0 : interval_sum_q;
		b_last   = cmd.fin ? '0 : last_onset_q;
		b_primed = cmd.fin | primed_q;

		n_min = (s_sel < b_min) ? s_sel : b_min;
		n_max = (s_sel > b_max) ? s_sel : b_max;
		s_ext = {s_sel[SAMPLE_BITS-1], s_sel};

		onset = b_primed && !burst_q && (s_ext > thresh_high_q);
		leave = b_primed && burst_q && (s_ext < thresh_low_q);

		gap   = (b_idx >= {1'b0, b_last}) ? (b_idx - {1'b0, b_last}) : '0;
		sum_w = {2'b00, b_sum} + {1'b0, gap};

		n_burst = burst_q;
		n_ons   = b_ons;
		n_sum   = b_sum;
		n_last  = b_last;
		if (onset) begin
			n_burst = 1'b1;
			n_ons   = (b_ons != COUNT_MAX) ? b_ons + 1'b1 : b_ons;
			n_sum   = (sum_w > {2'b00, COUNT_MAX}) ? COUNT_MAX : sum_w[COUNT_BITS-1:0];
			n_last  = b_idx[COUNT_BITS-1:0];
		end else if (leave) begin
			n_burst = 1'b0;
		end

		n_idx = (b_idx != INDEX_MAX) ? b_idx + 1'b1 : b_idx;
	end

	// range of the closing window, zero if empty
	assign diff  = {run_max_q[SAMPLE_BITS-1], run_max_q} - {run_min_q[SAMPLE_BITS-1], run_min_q};
	assign range = diff[THRESH_BITS-1] ? '0 : diff[SAMPLE_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_samples_q <= WINDOW_RESET;
			low_frac_q       <= LOW_RESET;
			high_frac_q      <= HIGH_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_WINDOW_SAMPLES: window_samples_q <= cfg_data;
				CFG_LOW_FRACTION:   low_frac_q       <= cfg_data[FRAC_BITS-1:0];
				CFG_HIGH_FRACTION:  high_frac_q      <= cfg_data[FRAC_BITS-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q      <= SAMPLE_MAX;
			run_max_q      <= SAMPLE_MIN;
			thresh_low_q   <= '0;
			thresh_high_q  <= '0;
			sample_index_q <= '0;
			onsets_q       <= '0;
			interval_sum_q <= '0;
			last_onset_q   <= '0;
			burst_q        <= 1'b0;
			primed_q       <= 1'b0;
		end else begin
			if (cmd.thr) begin
				thresh_low_q  <= {run_min_q[SAMPLE_BITS-1], run_min_q}
					+ {1'b0, prod_lo_q[PROD_BITS-1:FRAC_BITS]};
				thresh_high_q <= {run_min_q[SAMPLE_BITS-1], run_min_q}
					+ {1'b0, prod_hi_q[PROD_BITS-1:FRAC_BITS]};
			end
			if (cmd.upd || cmd.fin) begin
				run_min_q      <= n_min;
				run_max_q      <= n_max;
				sample_index_q <= n_idx;
				onsets_q       <= n_ons;
				interval_sum_q <= n_sum;
				last_onset_q   <= n_last;
				burst_q        <= n_burst;
			end
			if (cmd.fin) begin
				primed_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			samp_q <= sample;
		end
		if (cmd.mul) begin
			prod_lo_q <= {{FRAC_BITS{1'b0}}, range} * {{SAMPLE_BITS{1'b0}}, low_frac_q};
			prod_hi_q <= {{FRAC_BITS{1'b0}}, range} * {{SAMPLE_BITS{1'b0}}, high_frac_q};
		end
	end

	wbd_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (interval_sum_q),
		.divisor  (onsets_q),
		.busy     (div_busy),
		.quotient (quotient)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid_q <= 1'b0;
		end else if (cmd.fin) begin
			result_valid_q <= 1'b1;
		end else if (!result_stall) begin
			result_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.fin) begin
			window_min_q    <= run_min_q;
			window_max_q    <= run_max_q;
			onset_count_q   <= onsets_q;
			mean_interval_q <= (onsets_q != '0) ? quotient : '0;
			mean_valid_q    <= (onsets_q != '0);
			in_burst_q      <= n_burst;
		end
	end

	assign status.close_due = (sample_index_q > {1'b0, window_samples_q});
	assign status.div_busy  = div_busy;
	assign status.out_free  = !result_valid_q || !result_stall;

	assign result_valid  = result_valid_q;
	assign window_min    = window_min_q;
	assign window_max    = window_max_q;
	assign onset_count   = onset_count_q;
	assign mean_interval = mean_interval_q;
	assign mean_valid    = mean_valid_q;
	assign in_burst      = in_burst_q;

endmodule

`default_nettype wire

// ===== hdl/wbd_checker.sv =====
// ----------------------------------------------------------------------------
// Windowed burst detector checker
// Port-level properties of the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
`include "windowed_burst_detector_assert.svh"

module wbd_checker
	import wbd_pkg::*;
(
	input wire logic                          clk,
	input wire logic                          arst_n,
	input wire logic                          result_valid,
	input wire logic                          result_stall,
	input wire logic signed [SAMPLE_BITS-1:0] window_min,
	input wire logic signed [SAMPLE_BITS-1:0] window_max,
	input wire logic [COUNT_BITS-1:0]         onset_count,
	input wire logic [COUNT_BITS-1:0]         mean_interval,
	input wire logic                          mean_valid,
	input wire logic                          in_burst
);

	logic stalled;

	assign stalled = result_valid && result_stall;

	`WBD_ASSERT_NEXT(a_result_held, stalled, result_valid)
	`WBD_ASSERT_NEXT(a_payload_held, stalled,
		$stable(window_min) && $stable(window_max) && $stable(onset_count)
		&& $stable(mean_interval) && $stable(mean_valid) && $stable(in_burst))
	// mean is defined exactly when the window saw an onset
	`WBD_ASSERT_NOW(a_mean_flag, result_valid,
		(mean_valid == (onset_count != '0)) && (mean_valid || (mean_interval == '0)))
	// every closed window holds at least one sample, so its min never exceeds its max
	`WBD_ASSERT_NOW(a_min_le_max, result_valid, window_min <= window_max)

endmodule

bind windowed_burst_detector wbd_checker u_wbd_checker (.*);

`default_nettype wire
